FILE: rtl/mcfs_pkg.sv
// ============================================================================
// mcfs_pkg: shared definitions of the multi-camera frame sync detector
// Holds the slot count, register indexes, codes and the structures that
// travel between the front end and the sync engine.
// ============================================================================
package mcfs_pkg;

    // Number of camera slots; the camera field and the enable register cover eight.
    localparam int MAX_CAMERAS = 8;
    localparam int N_SLOT      = (MAX_CAMERAS < 8) ? MAX_CAMERAS : 8;
    localparam int SLOT_W      = $clog2(N_SLOT);

    // Depth of the command queue between the front end and the engine.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [23:0] IN_SYNC_RESET = 24'd21000;
    localparam logic [23:0] NO_SYNC_RESET = 24'd168000;
    localparam logic [23:0] SPREAD_SAT    = 24'hFFFFFF;

    typedef enum logic [1:0] {
        CFG_IN_SYNC = 2'd0,
        CFG_NO_SYNC = 2'd1,
        CFG_ENABLE  = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IN_SYNC  = 2'd0,
        ST_NOT_SYNC = 2'd1,
        ST_FATAL    = 2'd2,
        ST_DISABLED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_FRAME    = 2'd1,
        OP_DISABLED = 2'd2
    } t_op;

    typedef struct packed {
        logic [23:0] in_sync_limit;
        logic [23:0] no_sync_limit;
        logic [7:0]  enable;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [47:0]       frame_time;
        logic [47:0]       now;
    } t_cmd;

endpackage

FILE: rtl/multi_camera_frame_sync_detector.sv
// ============================================================================
// multi_camera_frame_sync_detector: decides when camera frames are in sync
// Flow: start and disabled-camera transactions, and frames rejected by the
//   fatal checks, load the result register straight from the idle state; a
//   scanned frame walks the scan state, one slot per cycle, then decides.
// Overlap: the engine takes no new command until the previous one has loaded
//   its result; further transactions wait in the front-end queue meanwhile.
// Reset: synchronous, active low; clears the control state, not the datapath.
// ============================================================================
module multi_camera_frame_sync_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wdata,
    // Input queue side.
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [2:0]  i_camera,
    input  logic [47:0] i_frame_time_us,
    input  logic [47:0] i_now_us,
    // Result queue side.
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [23:0] o_spread_us
);
    import mcfs_pkg::*;

    // The configuration registers. The user must let writes arrive only while
    // the block is idle (not enforced); front end and engine read them directly.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_sync_limit <= IN_SYNC_RESET;
            r_cfg.no_sync_limit <= NO_SYNC_RESET;
            r_cfg.enable        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IN_SYNC: r_cfg.in_sync_limit <= i_cfg_wdata;
                CFG_NO_SYNC: r_cfg.no_sync_limit <= i_cfg_wdata;
                CFG_ENABLE:  r_cfg.enable        <= i_cfg_wdata[7:0];
                default: begin
                    // Writes to an unlisted index are ignored.
                end
            endcase
        end
    end

    // The front end takes each input transaction, classifies it and queues it.
    // Its queue lets inputs keep arriving while the engine is scanning or a
    // result is still waiting to be popped.
    logic out_valid;
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    mcfs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .push            (push),
        .full            (full),
        .i_kind          (i_kind),
        .i_camera        (i_camera),
        .i_frame_time_us (i_frame_time_us),
        .i_now_us        (i_now_us),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    // The engine owns the frame stamps, used flags, last sync time and the
    // sticky fatal flag. It starts a command only when its result register is
    // free or being popped in the same cycle, so each command yields exactly
    // one result in order.
    mcfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (out_valid),
        .o_status    (o_status),
        .o_spread_us (o_spread_us),
        .i_pop       (pop)
    );

    assign empty = !out_valid;

endmodule

FILE: rtl/mcfs_front.sv
// ============================================================================
// mcfs_front: input acceptance and classification
// Sorts each incoming transaction into start, frame or disabled-camera
// commands and holds them in a short queue for the sync engine.
// ============================================================================
module mcfs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mcfs_pkg::t_cfg i_cfg,
    input  logic          push,
    output logic          full,
    input  logic          i_kind,
    input  logic [2:0]    i_camera,
    input  logic [47:0]   i_frame_time_us,
    input  logic [47:0]   i_now_us,
    output logic          o_cmd_valid,
    output mcfs_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import mcfs_pkg::*;

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic [N_SLOT-1:0] w_en;
    logic              w_slot_on;
    logic              w_wr;
    logic              w_rd;
    t_cmd              w_cmd;

    assign w_en = i_cfg.enable[N_SLOT-1:0];

    always_comb begin
        w_slot_on = 1'b0;
        if (int'(i_camera) < N_SLOT) begin
            w_slot_on = w_en[i_camera[SLOT_W-1:0]];
        end
        w_cmd.slot       = i_camera[SLOT_W-1:0];
        w_cmd.frame_time = i_frame_time_us;
        w_cmd.now        = i_now_us;
        if (!i_kind) begin
            w_cmd.op = OP_START;
        end else if (w_slot_on) begin
            w_cmd.op = OP_FRAME;
        end else begin
            w_cmd.op = OP_DISABLED;
        end
    end

    assign full        = (r_count == QCNT_W'(QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_wr        = push && !full;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!w_wr && w_rd) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

FILE: rtl/mcfs_back.sv
// ============================================================================
// mcfs_back: sync engine
// Keeps the per-camera timestamps and used flags, scans the slots one per
// cycle for the fresh spread, decides the status and holds the result.
// ============================================================================
module mcfs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mcfs_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  mcfs_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_out_valid,
    output logic [1:0]     o_status,
    output logic [23:0]    o_spread_us,
    input  logic           i_pop
);
    import mcfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(N_SLOT - 1);

    t_state            r_state, n_state;
    logic [47:0]       r_stamp [N_SLOT];
    logic [47:0]       n_stamp [N_SLOT];
    logic [N_SLOT-1:0] r_used, n_used;
    logic [47:0]       r_last, n_last;
    logic              r_fatal, n_fatal;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_any, n_any;
    logic              r_ready, n_ready;
    logic [47:0]       r_lo, n_lo;
    logic [47:0]       r_hi, n_hi;
    logic [47:0]       r_now, n_now;
    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [23:0]       r_spread, n_spread;

    logic [N_SLOT-1:0] w_en;
    logic [47:0]       w_cur;
    logic [47:0]       w_age;
    logic [47:0]       w_spread;
    logic              w_out_free;
    logic              w_load;

    assign w_en       = i_cfg.enable[N_SLOT-1:0];
    assign w_cur      = r_stamp[r_idx];
    assign w_age      = i_cmd.now - r_last;
    assign w_spread   = r_any ? (r_hi - r_lo) : 48'd0;
    assign w_out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state  = r_state;
        n_stamp  = r_stamp;
        n_used   = r_used;
        n_last   = r_last;
        n_fatal  = r_fatal;
        n_idx    = r_idx;
        n_any    = r_any;
        n_ready  = r_ready;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_now    = r_now;
        n_status = r_status;
        n_spread = r_spread;
        o_cmd_pop = 1'b0;
        w_load    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    n_spread  = '0;
                    case (i_cmd.op)
                        OP_START: begin
                            n_last   = i_cmd.now;
                            n_fatal  = 1'b0;
                            n_status = ST_NOT_SYNC;
                            w_load   = 1'b1;
                        end
                        OP_FRAME: begin
                            if (r_fatal) begin
                                n_status = ST_FATAL;
                                w_load   = 1'b1;
                            end else begin
                                n_stamp[i_cmd.slot] = i_cmd.frame_time;
                                n_used[i_cmd.slot]  = 1'b0;
                                if (i_cmd.now >= r_last &&
                                    w_age > 48'(i_cfg.no_sync_limit)) begin
                                    n_fatal  = 1'b1;
                                    n_status = ST_FATAL;
                                    w_load   = 1'b1;
                                end else begin
                                    n_now   = i_cmd.now;
                                    n_idx   = '0;
                                    n_any   = 1'b0;
                                    n_ready = 1'b1;
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        default: begin
                            n_status = ST_DISABLED;
                            w_load   = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_en[r_idx]) begin
                    if (w_cur < r_last) begin
                        n_used[r_idx] = 1'b1;
                        n_ready       = 1'b0;
                    end else begin
                        if (!r_any) begin
                            n_lo  = w_cur;
                            n_hi  = w_cur;
                            n_any = 1'b1;
                        end else begin
                            if (w_cur < r_lo) n_lo = w_cur;
                            if (w_cur > r_hi) n_hi = w_cur;
                        end
                        if (r_used[r_idx]) n_ready = 1'b0;
                    end
                end
                if (r_idx == LAST_SLOT) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_DECIDE: begin
                n_spread = (w_spread > 48'(SPREAD_SAT)) ? SPREAD_SAT : w_spread[23:0];
                if (r_ready && w_spread < 48'(i_cfg.in_sync_limit)) begin
                    n_used   = '1;
                    n_last   = r_now;
                    n_status = ST_IN_SYNC;
                end else if (w_spread > 48'(i_cfg.no_sync_limit)) begin
                    n_fatal  = 1'b1;
                    n_status = ST_FATAL;
                end else begin
                    n_status = ST_NOT_SYNC;
                end
                w_load  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stamp     <= '{default: '0};
            r_used      <= '1;
            r_last      <= '0;
            r_fatal     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stamp     <= n_stamp;
            r_used      <= n_used;
            r_last      <= n_last;
            r_fatal     <= n_fatal;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_any    <= n_any;
        r_ready  <= n_ready;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_now    <= n_now;
        r_status <= n_status;
        r_spread <= n_spread;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_spread_us = r_spread;

    // The result register must be free when a scanned frame reaches its decision.
    a_decide_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> !r_out_valid)
        else $error("result register busy at decision");

    // Commands leave the queue only while the engine is idle.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE))
        else $error("command taken while engine busy");

    // A decision always leaves a result waiting.
    a_decide_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |=> r_out_valid)
        else $error("decision produced no result");

    // The scan walks the slots one per cycle without skipping.
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_idx != LAST_SLOT) |=>
        (r_state == S_SCAN && r_idx == $past(r_idx) + SLOT_W'(1)))
        else $error("slot scan out of sequence");

endmodule
